// ===== hw/rtl/env_sensor_compensation_defines.svh =====
// assertion macros for the sensor compensation block
`ifndef ENV_SENSOR_COMPENSATION_DEFINES_SVH
`define ENV_SENSOR_COMPENSATION_DEFINES_SVH

// same-cycle implication, checked on clock, off during reset
`define ESC_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on clock, off during reset
`define ESC_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/esc_pkg.sv =====
// types, constants and helpers shared by the sensor compensation files
`default_nettype none
package esc_pkg;

   localparam int DivBits = 32;

   typedef enum logic [2:0] {
      REG_TEMP    = 3'd0,
      REG_PRESS_A = 3'd1,
      REG_PRESS_B = 3'd2,
      REG_MIXED   = 3'd3,
      REG_HUM     = 3'd4
   } esc_reg_type;

   typedef struct packed {
      logic [19:0] raw_temperature;
      logic [19:0] raw_pressure;
      logic [15:0] raw_humidity;
   } esc_req_type;

   typedef struct packed {
      logic signed [31:0] temperature_centi;
      logic signed [31:0] fine_temperature;
      logic [31:0]        pressure_pa;
      logic [16:0]        humidity_q10;
   } esc_rsp_type;

   // results carried alongside the pressure divide
   typedef struct packed {
      logic [31:0] temp;
      logic [31:0] tfine;
      logic [16:0] hum;
      logic        post_shift;
      logic        zero_div;
   } esc_side_type;

   typedef struct packed {
      logic [31:0]  dividend;
      logic [31:0]  divisor;
      esc_side_type side;
   } esc_div_in_type;

   typedef struct packed {
      logic [31:0]  quotient;
      esc_side_type side;
   } esc_div_out_type;

   function automatic logic [31:0] asr32(input logic [31:0] a, input int n);
      asr32 = 32'($signed(a) >>> n);
   endfunction

   function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
      mul32 = a * b;
   endfunction

   function automatic logic [31:0] sx16(input logic [15:0] a);
      sx16 = {{16{a[15]}}, a};
   endfunction

   function automatic logic [31:0] sx12(input logic [11:0] a);
      sx12 = {{20{a[11]}}, a};
   endfunction

   function automatic logic [31:0] sx8(input logic [7:0] a);
      sx8 = {{24{a[7]}}, a};
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/esc_div.sv =====
// pipelined restoring unsigned divider, one quotient bit per stage
`default_nettype none
module esc_div (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   input  wire esc_pkg::esc_div_in_type in_data,
   output logic                        out_valid,
   output esc_pkg::esc_div_out_type    out_data
);
   import esc_pkg::*;

   logic                 valid_ff [0:DivBits];
   logic [31:0]          rem_ff   [0:DivBits];
   logic [31:0]          quo_ff   [0:DivBits];
   logic [31:0]          dvd_ff   [0:DivBits];
   logic [31:0]          dvs_ff   [0:DivBits];
   esc_side_type         side_ff  [0:DivBits];

   assign valid_ff[0] = in_valid;
   assign rem_ff[0]   = '0;
   assign quo_ff[0]   = '0;
   assign dvd_ff[0]   = in_data.dividend;
   assign dvs_ff[0]   = in_data.divisor;
   assign side_ff[0]  = in_data.side;

   for (genvar i = 0; i < DivBits; i++) begin : g_step
      logic [32:0] trial;
      logic [32:0] diff;
      logic [31:0] rem_in;
      logic        bit_in;

      assign trial  = {rem_ff[i], dvd_ff[i][31]};
      assign diff   = trial - {1'b0, dvs_ff[i]};
      assign bit_in = !diff[32];
      assign rem_in = bit_in ? diff[31:0] : trial[31:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i+1] <= 1'b0;
         end else begin
            valid_ff[i+1] <= valid_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[i+1]  <= rem_in;
         quo_ff[i+1]  <= {quo_ff[i][30:0], bit_in};
         dvd_ff[i+1]  <= {dvd_ff[i][30:0], 1'b0};
         dvs_ff[i+1]  <= dvs_ff[i];
         side_ff[i+1] <= side_ff[i];
      end
   end

   assign out_valid         = valid_ff[DivBits];
   assign out_data.quotient = quo_ff[DivBits];
   assign out_data.side     = side_ff[DivBits];

endmodule
`default_nettype wire

// ===== hw/rtl/env_sensor_compensation.sv =====
// top level: integer compensation of one temperature, pressure and humidity reading
//
//   channel  ports                                  handshake
//   request  start, busy, req_data                  taken when start and not busy
//   response rsp_valid, rsp_data                    one-cycle strobe, never held off
//   csr      csr_valid, csr_ready, csr_index, ...   written when valid and ready
//
// one transaction per cycle while not in reset; 12 front stages, 32 divider stages, 3 back stages,
// the 32 divider stages coming from the one-bit-per-stage pressure divide
// busy is high only during reset; csr_ready is always high
// reset clears valid bits and coefficient registers; data registers are not reset
`default_nettype none
`include "env_sensor_compensation_defines.svh"
module env_sensor_compensation (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire esc_pkg::esc_req_type req_data,
   output logic                     rsp_valid,
   output esc_pkg::esc_rsp_type     rsp_data,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [2:0]          csr_index,
   input  wire logic [63:0]         csr_wdata
);
   import esc_pkg::*;

   // coefficient registers
   logic [47:0] temp_ff;
   logic [63:0] press_a_ff;
   logic [63:0] press_b_ff;
   logic [47:0] mixed_ff;
   logic [31:0] hum_ff;

   assign busy      = reset;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_ff    <= '0;
         press_a_ff <= '0;
         press_b_ff <= '0;
         mixed_ff   <= '0;
         hum_ff     <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (esc_reg_type'(csr_index))
            REG_TEMP:    temp_ff    <= csr_wdata[47:0];
            REG_PRESS_A: press_a_ff <= csr_wdata;
            REG_PRESS_B: press_b_ff <= csr_wdata;
            REG_MIXED:   mixed_ff   <= csr_wdata[47:0];
            REG_HUM:     hum_ff     <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, h1, h2, h3, h4, h5, h6;
   assign t1 = {16'b0, temp_ff[15:0]};
   assign t2 = sx16(temp_ff[31:16]);
   assign t3 = sx16(temp_ff[47:32]);
   assign p1 = {16'b0, press_a_ff[15:0]};
   assign p2 = sx16(press_a_ff[31:16]);
   assign p3 = sx16(press_a_ff[47:32]);
   assign p4 = sx16(press_a_ff[63:48]);
   assign p5 = sx16(press_b_ff[15:0]);
   assign p6 = sx16(press_b_ff[31:16]);
   assign p7 = sx16(press_b_ff[47:32]);
   assign p8 = sx16(press_b_ff[63:48]);
   assign p9 = sx16(mixed_ff[15:0]);
   assign h1 = {24'b0, mixed_ff[23:16]};
   assign h2 = sx16(mixed_ff[39:24]);
   assign h3 = {24'b0, mixed_ff[47:40]};
   assign h4 = sx12(hum_ff[11:0]);
   assign h5 = sx12(hum_ff[23:12]);
   assign h6 = sx8(hum_ff[31:24]);

   // valid bits of the front and back stages
   logic [12:1] fv_ff;
   logic        pa_valid_ff, pb_valid_ff;
   logic        accept;
   assign accept = start && !busy;

   // stage payload registers
   logic [31:0] s1_m1_ff, s1_m2_ff;
   logic [19:0] s1_adcp_ff, s2_adcp_ff, s3_adcp_ff, s4_adcp_ff, s5_adcp_ff, s6_adcp_ff;
   logic [19:0] s7_adcp_ff;
   logic [15:0] s1_adch_ff, s2_adch_ff, s3_adch_ff, s4_adch_ff, s5_adch_ff;
   logic [31:0] s2_v1t_ff, s2_m3_ff;
   logic [31:0] s3_tf_ff;
   logic [31:0] s4_pv1_ff, s4_x_ff;
   logic [31:0] s5_qq_ff, s5_mp5_ff, s5_mp2_ff, s5_mh6_ff, s5_mh3_ff, s5_mh5_ff;
   logic [31:0] s6_v2a_ff, s6_mp3_ff, s6_mp5_ff, s6_mp2_ff, s6_b_ff, s6_c_ff, s6_ha_ff;
   logic [31:0] s7_v2_ff, s7_v1s_ff, s7_bc_ff, s7_ha_ff;
   logic [31:0] s8_v1m_ff, s8_pm_ff, s8_eh_ff, s8_ha_ff;
   logic [31:0] s9_v1_ff, s9_dvd_ff, s9_hx_ff;
   logic [31:0] s10_hx_ff, s10_ss_ff, s11_hx_ff, s11_t_ff;
   logic [31:0] s10_v1_ff, s10_dvd_ff, s11_v1_ff, s11_dvd_ff, s12_v1_ff, s12_dvd_ff;
   logic [16:0] s12_hum_ff;
   logic        s9_post_ff, s10_post_ff, s11_post_ff, s12_post_ff;
   logic        s9_zero_ff, s10_zero_ff, s11_zero_ff, s12_zero_ff;
   // temperature and fine temperature ride along from stage 4
   logic [31:0] tmp_ff  [4:12];
   logic [31:0] tfr_ff  [4:12];

   // combinational helpers
   logic [31:0] adct, s1_a_in, s1_d_in, s4_pv1_in, s4_temp_in;
   logic [31:0] s6_ha_in, s9_v1_in, s9_e_in, s12_hf_in, s12_hc_in;

   assign adct       = {12'b0, req_data.raw_temperature};
   assign s1_a_in    = (adct >> 3) - {t1[30:0], 1'b0};
   assign s1_d_in    = (adct >> 4) - t1;
   assign s4_pv1_in  = asr32(s3_tf_ff, 1) - 32'd64000;
   assign s4_temp_in = asr32({s3_tf_ff[29:0], 2'b0} + s3_tf_ff + 32'd128, 8);
   assign s6_ha_in   = asr32({2'b0, s5_adch_ff, 14'b0} - {h4[11:0], 20'b0} - s5_mh5_ff
                             + 32'd16384, 15);
   assign s9_v1_in   = asr32(s8_v1m_ff, 15);
   assign s9_e_in    = asr32(s8_eh_ff + 32'd8192, 14);
   assign s12_hf_in  = s11_hx_ff - asr32(s11_t_ff, 4);
   assign s12_hc_in  = s12_hf_in[31] ? 32'd0 :
                       (s12_hf_in > 32'd419430400) ? 32'd419430400 : s12_hf_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= '0;
      end else begin
         fv_ff <= {fv_ff[11:1], accept};
      end
   end

   always_ff @(posedge clock) begin
      // temperature
      s1_m1_ff   <= mul32(s1_a_in, t2);
      s1_m2_ff   <= mul32(s1_d_in, s1_d_in);
      s1_adcp_ff <= req_data.raw_pressure;
      s1_adch_ff <= req_data.raw_humidity;
      s2_v1t_ff  <= asr32(s1_m1_ff, 11);
      s2_m3_ff   <= mul32(asr32(s1_m2_ff, 12), t3);
      s2_adcp_ff <= s1_adcp_ff;
      s2_adch_ff <= s1_adch_ff;
      s3_tf_ff   <= s2_v1t_ff + asr32(s2_m3_ff, 14);
      s3_adcp_ff <= s2_adcp_ff;
      s3_adch_ff <= s2_adch_ff;
      // split into pressure and humidity terms
      tmp_ff[4]  <= s4_temp_in;
      tfr_ff[4]  <= s3_tf_ff;
      s4_pv1_ff  <= s4_pv1_in;
      s4_x_ff    <= s3_tf_ff - 32'd76800;
      s4_adcp_ff <= s3_adcp_ff;
      s4_adch_ff <= s3_adch_ff;
      s5_qq_ff   <= mul32(asr32(s4_pv1_ff, 2), asr32(s4_pv1_ff, 2));
      s5_mp5_ff  <= mul32(s4_pv1_ff, p5);
      s5_mp2_ff  <= mul32(p2, s4_pv1_ff);
      s5_mh6_ff  <= mul32(s4_x_ff, h6);
      s5_mh3_ff  <= mul32(s4_x_ff, h3);
      s5_mh5_ff  <= mul32(h5, s4_x_ff);
      s5_adcp_ff <= s4_adcp_ff;
      s5_adch_ff <= s4_adch_ff;
      s6_v2a_ff  <= mul32(asr32(s5_qq_ff, 11), p6);
      s6_mp3_ff  <= mul32(p3, asr32(s5_qq_ff, 13));
      s6_mp5_ff  <= s5_mp5_ff;
      s6_mp2_ff  <= s5_mp2_ff;
      s6_b_ff    <= asr32(s5_mh6_ff, 10);
      s6_c_ff    <= asr32(s5_mh3_ff, 11) + 32'd32768;
      s6_ha_ff   <= s6_ha_in;
      s6_adcp_ff <= s5_adcp_ff;
      s7_v2_ff   <= asr32(s6_v2a_ff + {s6_mp5_ff[30:0], 1'b0}, 2) + {p4[15:0], 16'b0};
      s7_v1s_ff  <= asr32(asr32(s6_mp3_ff, 3) + asr32(s6_mp2_ff, 1), 18);
      s7_bc_ff   <= mul32(s6_b_ff, s6_c_ff);
      s7_ha_ff   <= s6_ha_ff;
      s7_adcp_ff <= s6_adcp_ff;
      s8_v1m_ff  <= mul32(32'd32768 + s7_v1s_ff, p1);
      s8_pm_ff   <= mul32((32'd1048576 - {12'b0, s7_adcp_ff}) - asr32(s7_v2_ff, 12),
                          32'd3125);
      s8_eh_ff   <= mul32(asr32(s7_bc_ff, 10) + 32'd2097152, h2);
      s8_ha_ff   <= s7_ha_ff;
      // large dividends are divided first and doubled afterwards
      s9_v1_ff   <= s9_v1_in;
      s9_dvd_ff  <= s8_pm_ff[31] ? s8_pm_ff : {s8_pm_ff[30:0], 1'b0};
      s9_post_ff <= s8_pm_ff[31];
      s9_zero_ff <= (s9_v1_in == 32'd0);
      s9_hx_ff   <= mul32(s8_ha_ff, s9_e_in);
      s10_hx_ff  <= s9_hx_ff;
      s10_ss_ff  <= mul32(asr32(s9_hx_ff, 15), asr32(s9_hx_ff, 15));
      s11_hx_ff  <= s10_hx_ff;
      s11_t_ff   <= mul32(asr32(s10_ss_ff, 7), h1);
      s12_hum_ff <= s12_hc_in[28:12];
      s10_v1_ff  <= s9_v1_ff;   s11_v1_ff  <= s10_v1_ff;   s12_v1_ff  <= s11_v1_ff;
      s10_dvd_ff <= s9_dvd_ff;  s11_dvd_ff <= s10_dvd_ff;  s12_dvd_ff <= s11_dvd_ff;
      s10_post_ff <= s9_post_ff; s11_post_ff <= s10_post_ff; s12_post_ff <= s11_post_ff;
      s10_zero_ff <= s9_zero_ff; s11_zero_ff <= s10_zero_ff; s12_zero_ff <= s11_zero_ff;
   end

   for (genvar k = 5; k <= 12; k++) begin : g_carry
      always_ff @(posedge clock) begin
         tmp_ff[k] <= tmp_ff[k-1];
         tfr_ff[k] <= tfr_ff[k-1];
      end
   end

   // pressure divide
   esc_div_in_type  div_in;
   esc_div_out_type div_out;
   logic            div_out_valid;

   assign div_in.dividend        = s12_dvd_ff;
   assign div_in.divisor         = s12_v1_ff;
   assign div_in.side.temp       = tmp_ff[12];
   assign div_in.side.tfine      = tfr_ff[12];
   assign div_in.side.hum        = s12_hum_ff;
   assign div_in.side.post_shift = s12_post_ff;
   assign div_in.side.zero_div   = s12_zero_ff;

   esc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .in_valid (fv_ff[12]),
      .in_data  (div_in),
      .out_valid(div_out_valid),
      .out_data (div_out)
   );

   // back stages: pressure correction terms
   logic [31:0]  pa_pres_in;
   logic [31:0]  pa_pres_ff, pa_sq_ff, pa_w2m_ff, pb_pres_ff, pb_w1m_ff, pb_w2_ff;
   esc_side_type pa_side_ff, pb_side_ff;

   assign pa_pres_in = div_out.side.post_shift ? {div_out.quotient[30:0], 1'b0}
                                               : div_out.quotient;

   always_ff @(posedge clock) begin
      if (reset) begin
         pa_valid_ff <= 1'b0;
         pb_valid_ff <= 1'b0;
         rsp_valid   <= 1'b0;
      end else begin
         pa_valid_ff <= div_out_valid;
         pb_valid_ff <= pa_valid_ff;
         rsp_valid   <= pb_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      pa_pres_ff <= pa_pres_in;
      pa_sq_ff   <= mul32(pa_pres_in >> 3, pa_pres_in >> 3);
      pa_w2m_ff  <= mul32(pa_pres_in >> 2, p8);
      pa_side_ff <= div_out.side;
      pb_pres_ff <= pa_pres_ff;
      pb_w1m_ff  <= mul32(p9, pa_sq_ff >> 13);
      pb_w2_ff   <= asr32(pa_w2m_ff, 13);
      pb_side_ff <= pa_side_ff;
      rsp_data.temperature_centi <= pb_side_ff.temp;
      rsp_data.fine_temperature  <= pb_side_ff.tfine;
      rsp_data.humidity_q10      <= pb_side_ff.hum;
      rsp_data.pressure_pa       <= pb_side_ff.zero_div ? 32'd0 :
         pb_pres_ff + asr32(asr32(pb_w1m_ff, 12) + pb_w2_ff + p7, 4);
   end

   `ESC_ASSERT_IMP(a_hum_range, rsp_valid, rsp_data.humidity_q10 <= 17'd102400, "humidity out of range")
   `ESC_ASSERT_NXT(a_zero_div, pb_valid_ff && pb_side_ff.zero_div, rsp_valid && rsp_data.pressure_pa == 32'd0, "zero divisor gave nonzero pressure")
   `ESC_ASSERT_NXT(a_div_flow, div_out_valid, pa_valid_ff, "divider transaction lost")

endmodule
`default_nettype wire

// ===== tb/sv/tb_env_sensor_compensation.sv =====
// testbench for the sensor compensation block: queued driver, strobe monitor, inline predictor
`timescale 1ns / 1ps
module tb_env_sensor_compensation;
   import esc_pkg::*;

   localparam int Latency   = 47;
   localparam int WatchLimit = 2000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   esc_req_type req_data = '0;
   logic rsp_valid;
   esc_rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [63:0] csr_wdata = '0;

   env_sensor_compensation DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   logic [63:0] coeff_regs [5];
   esc_req_type pending_q[$];
   esc_rsp_type compensated_q[$];
   int mismatch_count = 0;
   int result_count = 0;
   int sent_count = 0;
   int idle_pct = 0;
   int idle_cycles = 0;
   bit hold_off = 1'b0;

   function automatic logic [31:0] fsext(logic [63:0] r, int lo, int w, bit sgn);
      logic [31:0] m;
      logic [31:0] v;
      m = (w == 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 32'd1);
      v = 32'(r >> lo) & m;
      if (sgn && v[w-1]) v = v | ~m;
      return v;
   endfunction

   function automatic logic [31:0] sra(logic [31:0] a, int n);
      return $signed(a) >>> n;
   endfunction

   function automatic esc_rsp_type compensate(esc_req_type it);
      logic [31:0] adc_t, adc_p, adc_h;
      logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, h1, h2, h3, h4, h5, h6;
      logic [31:0] v1, v2, q, d, tf, temp, pres, w1, w2, x, a, b, c, e, s;
      esc_rsp_type r;
      adc_t = 32'(it.raw_temperature);
      adc_p = 32'(it.raw_pressure);
      adc_h = 32'(it.raw_humidity);
      t1 = fsext(coeff_regs[REG_TEMP], 0, 16, 0);
      t2 = fsext(coeff_regs[REG_TEMP], 16, 16, 1);
      t3 = fsext(coeff_regs[REG_TEMP], 32, 16, 1);
      p1 = fsext(coeff_regs[REG_PRESS_A], 0, 16, 0);
      p2 = fsext(coeff_regs[REG_PRESS_A], 16, 16, 1);
      p3 = fsext(coeff_regs[REG_PRESS_A], 32, 16, 1);
      p4 = fsext(coeff_regs[REG_PRESS_A], 48, 16, 1);
      p5 = fsext(coeff_regs[REG_PRESS_B], 0, 16, 1);
      p6 = fsext(coeff_regs[REG_PRESS_B], 16, 16, 1);
      p7 = fsext(coeff_regs[REG_PRESS_B], 32, 16, 1);
      p8 = fsext(coeff_regs[REG_PRESS_B], 48, 16, 1);
      p9 = fsext(coeff_regs[REG_MIXED], 0, 16, 1);
      h1 = fsext(coeff_regs[REG_MIXED], 16, 8, 0);
      h2 = fsext(coeff_regs[REG_MIXED], 24, 16, 1);
      h3 = fsext(coeff_regs[REG_MIXED], 40, 8, 0);
      h4 = fsext(coeff_regs[REG_HUM], 0, 12, 1);
      h5 = fsext(coeff_regs[REG_HUM], 12, 12, 1);
      h6 = fsext(coeff_regs[REG_HUM], 24, 8, 1);

      v1 = sra(((adc_t >> 3) - (t1 << 1)) * t2, 11);
      d = (adc_t >> 4) - t1;
      v2 = sra(sra(d * d, 12) * t3, 14);
      tf = v1 + v2;
      temp = sra(tf * 32'd5 + 32'd128, 8);

      v1 = sra(tf, 1) - 32'd64000;
      q = sra(v1, 2);
      v2 = sra(q * q, 11) * p6;
      v2 = v2 + ((v1 * p5) << 1);
      v2 = sra(v2, 2) + (p4 << 16);
      v1 = sra(sra(p3 * sra(q * q, 13), 3) + sra(p2 * v1, 1), 18);
      v1 = sra((32'd32768 + v1) * p1, 15);
      if (v1 == 32'd0) begin
         pres = 32'd0;
      end else begin
         pres = ((32'd1048576 - adc_p) - sra(v2, 12)) * 32'd3125;
         if (pres < 32'h8000_0000) pres = (pres << 1) / v1;
         else pres = (pres / v1) << 1;
         w1 = sra(p9 * (((pres >> 3) * (pres >> 3)) >> 13), 12);
         w2 = sra((pres >> 2) * p8, 13);
         pres = pres + sra(w1 + w2 + p7, 4);
      end

      x = tf - 32'd76800;
      a = sra((adc_h << 14) - (h4 << 20) - h5 * x + 32'd16384, 15);
      b = sra(x * h6, 10);
      c = sra(x * h3, 11) + 32'd32768;
      e = sra((sra(b * c, 10) + 32'd2097152) * h2 + 32'd8192, 14);
      x = a * e;
      s = sra(x, 15);
      x = x - sra(sra(s * s, 7) * h1, 4);
      if (x[31]) x = 32'd0;
      else if (x > 32'd419430400) x = 32'd419430400;

      r.temperature_centi = temp;
      r.fine_temperature = tf;
      r.pressure_pa = pres;
      r.humidity_q10 = 17'(x >> 12);
      return r;
   endfunction

   // driver: one transaction per accepted start, prediction taken at acceptance
   always @(negedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            compensated_q.push_back(compensate(pending_q.pop_front()));
            sent_count++;
         end
         if (pending_q.size() > 0 && !hold_off && ($urandom_range(99) >= idle_pct)) begin
            start <= 1'b1;
            req_data <= pending_q[0];
         end else begin
            start <= 1'b0;
            req_data <= esc_req_type'({$urandom, $urandom});
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         result_count++;
         if (compensated_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected result %p", rsp_data);
         end else begin
            esc_rsp_type want;
            want = compensated_q.pop_front();
            if (rsp_data.temperature_centi !== want.temperature_centi ||
                rsp_data.fine_temperature !== want.fine_temperature ||
                rsp_data.pressure_pa !== want.pressure_pa ||
                rsp_data.humidity_q10 !== want.humidity_q10) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected t=%0d tf=%0d p=%0d h=%0d got t=%0d tf=%0d p=%0d h=%0d",
                     want.temperature_centi, want.fine_temperature, want.pressure_pa,
                     want.humidity_q10, rsp_data.temperature_centi, rsp_data.fine_temperature,
                     rsp_data.pressure_pa, rsp_data.humidity_q10);
            end
         end
      end
   end

   // watchdog on cycles with no transaction
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
         $display("watchdog expired");
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx <= REG_HUM) begin
         case (idx)
            REG_TEMP, REG_MIXED: coeff_regs[idx] = val & 64'hFFFF_FFFF_FFFF;
            REG_HUM: coeff_regs[idx] = val & 64'hFFFF_FFFF;
            default: coeff_regs[idx] = val;
         endcase
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      while (pending_q.size() > 0 || compensated_q.size() > 0) @(posedge clock);
      repeat (Latency + 5) @(posedge clock);
   endtask

   // all-zero, all-ones, typical trim values with random perturbation, or fully random values
   task automatic load_coeffs(input int mode);
      logic [63:0] v [5];
      case (mode)
         0: for (int i = 0; i < 5; i++) v[i] = '0;
         1: for (int i = 0; i < 5; i++) v[i] = '1;
         2: begin
            v[0] = {16'd50, 16'd26435, 16'd27504};
            v[1] = {16'd2855, 16'd3024, -16'sd10685, 16'd36477};
            v[2] = {16'sd15500, -16'sd14600, -16'sd7, 16'd140};
            v[3] = {8'd0, 16'd359, 8'd75, 16'd6000};
            v[4] = {8'd30, 12'd50, 12'd340};
            for (int i = 0; i < 5; i++)
               if ($urandom_range(1)) v[i] = v[i] ^ 64'($urandom_range(255));
         end
         default: for (int i = 0; i < 5; i++) v[i] = {$urandom, $urandom};
      endcase
      for (int i = 0; i < 5; i++) write_reg(3'(i), v[i]);
      write_reg(3'd5 + 3'($urandom_range(2)), {$urandom, $urandom});
   endtask

   function automatic esc_req_type rand_item(bit realistic);
      esc_req_type it;
      if (realistic) begin
         it.raw_temperature = 20'($urandom_range(400000, 600000));
         it.raw_pressure = 20'($urandom_range(250000, 450000));
         it.raw_humidity = 16'($urandom_range(20000, 40000));
      end else begin
         it = esc_req_type'($urandom ^ ({$urandom, $urandom} << 24));
      end
      return it;
   endfunction

   initial begin
      esc_req_type it;
      for (int i = 0; i < 5; i++) coeff_regs[i] = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: zero coefficients give zero divisor, then extremes under several settings
      for (int m = 0; m < 3; m++) begin
         load_coeffs(m);
         pending_q.push_back('0);
         pending_q.push_back('1);
         it = '0; it.raw_temperature = '1; pending_q.push_back(it);
         it = '0; it.raw_pressure = '1; pending_q.push_back(it);
         it = '0; it.raw_humidity = '1; pending_q.push_back(it);
         pending_q.push_back(rand_item(1));
         drain();
      end

      for (int ph = 0; ph < 8; ph++) begin
         load_coeffs(ph % 4 == 3 ? 3 : 2);
         idle_pct = (ph % 4 == 1) ? 57 : (ph % 4 == 3) ? 25 : 0;
         for (int n = 0; n < 90; n++) pending_q.push_back(rand_item($urandom_range(99) < 75));
         if (ph == 4) begin
            while (pending_q.size() > 50) @(posedge clock);
            hold_off = 1'b1;
            while (compensated_q.size() > 0) @(posedge clock);
            hold_off = 1'b0;
         end
         drain();
      end

      $display("%0d readings sent, %0d results checked over several coefficient sets",
         sent_count, result_count);
      if (mismatch_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end
endmodule
